// File: rtl/dmsh_pkg.sv
// dmsh_pkg: shared types, constants and helpers for the displaced multiply-shift hash
// no dependencies; used by every module of the block

package dmsh_pkg;

  // displacement table geometry (depth is a power of two)
  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned TBL_IDX_W   = $clog2(TABLE_DEPTH);

  // field widths
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned ENTRY_W  = 8;
  localparam int unsigned WIDX_W   = 6;
  localparam int unsigned SHIFT_W  = 5;
  localparam int unsigned HASH_W   = 32;

  // stream payload widths
  localparam int unsigned IN_BITS    = 2 * KEY_W + WIDX_W + ENTRY_W;
  localparam int unsigned IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = HASH_W;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // queue between front and back
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef logic [TBL_IDX_W-1:0]  tbl_idx_t;
  typedef logic [FIFO_CNT_W-1:0] fifo_cnt_t;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MULT_F  = 3'd0,
    REG_MULT_G  = 3'd1,
    REG_ADD_F   = 3'd2,
    REG_ADD_G   = 3'd3,
    REG_SHIFT_F = 3'd4,
    REG_SHIFT_G = 3'd5
  } cfg_reg_e;

  // item kinds carried in tuser
  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_WRITE  = 1'b1
  } op_kind_e;

  // classified item as queued for the back end
  typedef struct packed {
    op_kind_e           kind;
    logic [KEY_W-1:0]   key_f;
    logic [KEY_W-1:0]   key_g;
    tbl_idx_t           idx;
    logic [ENTRY_W-1:0] val;
  } op_t;

  // live configuration
  typedef struct packed {
    logic [KEY_W-1:0]   mult_f;
    logic [KEY_W-1:0]   mult_g;
    logic [KEY_W-1:0]   add_f;
    logic [KEY_W-1:0]   add_g;
    logic [SHIFT_W-1:0] shift_f;
    logic [SHIFT_W-1:0] shift_g;
  } cfg_t;

  // queue status seen by the top level
  typedef struct packed {
    logic      full;
    logic      empty;
    fifo_cnt_t cnt;
  } fifo_stat_t;

  // table slot of a 32-bit value: low bits, since the depth is a power of two
  function automatic tbl_idx_t tbl_index_of(logic [KEY_W-1:0] v);
    tbl_index_of = v[TBL_IDX_W-1:0];
  endfunction

endpackage

// File: rtl/displaced_multiply_shift_hash.sv
// displaced_multiply_shift_hash: two-lane multiply-shift hash with a displacement table.
// a lookup passes the front holding register, the op queue, stages 1 to 3 and the output register to m_axis.
// throughput: one item per cycle while m_axis is not stalled; the queue of 4 ops lets input and output stall apart.
// table writes take the same pipeline as lookups, so lookups see writes in item order.
// reset (rst_ni low, asynchronous): config and control registers return to defaults, table reads as zero.
// depends on dmsh_pkg, dmsh_front, dmsh_fifo, dmsh_back

module displaced_multiply_shift_hash (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // tdata: key_f[31:0], key_g[63:32], entry_index[69:64], entry_value[77:70], zero pad
  input  logic [dmsh_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // tuser: action
  input  logic                                s_axis_tuser,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: hash_value
  output logic [dmsh_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dmsh_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dmsh_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  dmsh_pkg::cfg_t       cfg_q, cfg_d;
  logic                 push, pop;
  dmsh_pkg::op_t        front_op, head_op;
  dmsh_pkg::fifo_stat_t fifo_stat;

  assign cfg_ready_o = 1'b1;

  // configuration register decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (dmsh_pkg::cfg_reg_e'(cfg_index_i))
        dmsh_pkg::REG_MULT_F:  cfg_d.mult_f  = cfg_data_i;
        dmsh_pkg::REG_MULT_G:  cfg_d.mult_g  = cfg_data_i;
        dmsh_pkg::REG_ADD_F:   cfg_d.add_f   = cfg_data_i;
        dmsh_pkg::REG_ADD_G:   cfg_d.add_g   = cfg_data_i;
        dmsh_pkg::REG_SHIFT_F: cfg_d.shift_f = cfg_data_i[dmsh_pkg::SHIFT_W-1:0];
        dmsh_pkg::REG_SHIFT_G: cfg_d.shift_g = cfg_data_i[dmsh_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mult_f  <= 32'd1;
      cfg_q.mult_g  <= 32'd1;
      cfg_q.add_f   <= 32'd0;
      cfg_q.add_g   <= 32'd0;
      cfg_q.shift_f <= 5'd29;
      cfg_q.shift_g <= 5'd26;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front end
  dmsh_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .push_o        (push),
    .op_o          (front_op),
    .full_i        (fifo_stat.full)
  );

  // op queue
  dmsh_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .op_i   (front_op),
    .pop_i  (pop),
    .op_o   (head_op),
    .stat_o (fifo_stat)
  );

  // back end
  dmsh_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .head_vld_i    (!fifo_stat.empty),
    .head_op_i     (head_op),
    .pop_o         (pop),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  // queue never overflows
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !fifo_stat.full)
    else $error("op queue written while full");

  // queue never underflows
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_stat.empty)
    else $error("op queue read while empty");

  // fill count rises by one on a push without a pop
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (fifo_stat.cnt == $past(fifo_stat.cnt) + 1'b1))
    else $error("op queue count lost a push");

endmodule

// File: rtl/dmsh_front.sv
// dmsh_front: input stage, accepts stream items and classifies them into queue ops
// depends on dmsh_pkg

module dmsh_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // tdata: key_f[31:0], key_g[63:32], entry_index[69:64], entry_value[77:70], zero pad
  input  logic [dmsh_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // tuser: action
  input  logic                               s_axis_tuser,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  output logic                               push_o,
  output dmsh_pkg::op_t                      op_o,
  input  logic                               full_i
);

  logic          vld_q, vld_d;
  dmsh_pkg::op_t op_q, op_d;
  logic          accept;

  // hand the held item to the queue when there is room
  assign push_o        = vld_q && !full_i;
  assign s_axis_tready = !vld_q || !full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign op_o          = op_q;

  // unpack and classify the incoming item
  always_comb begin
    op_d       = op_q;
    op_d.kind  = dmsh_pkg::op_kind_e'(s_axis_tuser);
    op_d.key_f = s_axis_tdata[31:0];
    op_d.key_g = s_axis_tdata[63:32];
    op_d.idx   = dmsh_pkg::tbl_index_of(dmsh_pkg::KEY_W'(s_axis_tdata[69:64]));
    op_d.val   = s_axis_tdata[77:70];
  end

  // holding register valid
  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (push_o) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= op_d;
    end
  end

endmodule

// File: rtl/dmsh_fifo.sv
// dmsh_fifo: short queue of classified ops between front and back
// depends on dmsh_pkg

module dmsh_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  dmsh_pkg::op_t        op_i,
  input  logic                 pop_i,
  output dmsh_pkg::op_t        op_o,
  output dmsh_pkg::fifo_stat_t stat_o
);

  dmsh_pkg::op_t                    mem_q [dmsh_pkg::FIFO_DEPTH];
  logic [dmsh_pkg::FIFO_PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [dmsh_pkg::FIFO_PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  dmsh_pkg::fifo_cnt_t              cnt_q, cnt_d;

  assign op_o         = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == dmsh_pkg::fifo_cnt_t'(dmsh_pkg::FIFO_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.cnt   = cnt_q;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

// File: rtl/dmsh_back.sv
// dmsh_back: hash pipeline (multiply, add and shift, table access, xor) and output register
// depends on dmsh_pkg; holds the displacement table memory

module dmsh_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dmsh_pkg::cfg_t                      cfg_i,
  input  logic                                head_vld_i,
  input  dmsh_pkg::op_t                       head_op_i,
  output logic                                pop_o,
  // tdata: hash_value
  output logic [dmsh_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready
);

  localparam int unsigned KW = dmsh_pkg::KEY_W;
  localparam int unsigned EW = dmsh_pkg::ENTRY_W;

  logic advance;

  // stage 1: lane products
  logic                s1_vld_q;
  dmsh_pkg::op_kind_e  s1_kind_q;
  dmsh_pkg::tbl_idx_t  s1_idx_q;
  logic [EW-1:0]       s1_val_q;
  logic [KW-1:0]       s1_pf_q, s1_pg_q;

  // stage 2: lane values, table address
  logic                s2_vld_q;
  dmsh_pkg::op_kind_e  s2_kind_q;
  dmsh_pkg::tbl_idx_t  s2_idx_q;
  logic [EW-1:0]       s2_val_q;
  logic [KW-1:0]       s2_f_q;

  // stage 3: table read data
  logic                s3_vld_q;
  logic [KW-1:0]       s3_f_q;
  logic [EW-1:0]       rd_q;
  logic                rd_ok_q;

  // output register
  logic                out_vld_q;
  logic [KW-1:0]       out_data_q;

  // displacement table with per-entry written flags
  logic [EW-1:0]                      tbl_mem [dmsh_pkg::TABLE_DEPTH];
  logic [dmsh_pkg::TABLE_DEPTH-1:0]   tbl_vld_q;

  logic [KW-1:0]       f_d, g_d;
  logic [EW-1:0]       disp;

  // whole pipeline moves unless a result sits unread
  assign advance = !out_vld_q || m_axis_tready;
  assign pop_o   = advance && head_vld_i;

  // add offset, then shift
  assign f_d  = (s1_pf_q + cfg_i.add_f) >> cfg_i.shift_f;
  assign g_d  = (s1_pg_q + cfg_i.add_g) >> cfg_i.shift_g;
  assign disp = rd_ok_q ? rd_q : '0;

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // control: stage valids and table written flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      tbl_vld_q <= '0;
    end else if (advance) begin
      s1_vld_q  <= head_vld_i;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q && (s2_kind_q == dmsh_pkg::OP_LOOKUP);
      out_vld_q <= s3_vld_q;
      if (s2_vld_q && (s2_kind_q == dmsh_pkg::OP_WRITE)) begin
        tbl_vld_q[s2_idx_q] <= 1'b1;
      end
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_kind_q  <= head_op_i.kind;
      s1_idx_q   <= head_op_i.idx;
      s1_val_q   <= head_op_i.val;
      s1_pf_q    <= head_op_i.key_f * cfg_i.mult_f;
      s1_pg_q    <= head_op_i.key_g * cfg_i.mult_g;
      s2_kind_q  <= s1_kind_q;
      s2_val_q   <= s1_val_q;
      s2_f_q     <= f_d;
      s2_idx_q   <= (s1_kind_q == dmsh_pkg::OP_WRITE) ? s1_idx_q
                                                      : dmsh_pkg::tbl_index_of(g_d);
      s3_f_q     <= s2_f_q;
      out_data_q <= s3_f_q ^ KW'(disp);
    end
  end

  // table memory: one write or one registered read per cycle while the pipeline advances, in item order
  always_ff @(posedge clk_i) begin
    if (advance && s2_vld_q) begin
      if (s2_kind_q == dmsh_pkg::OP_WRITE) begin
        tbl_mem[s2_idx_q] <= s2_val_q;
      end else begin
        rd_q    <= tbl_mem[s2_idx_q];
        rd_ok_q <= tbl_vld_q[s2_idx_q];
      end
    end
  end

endmodule
